>>> rtl/xxh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, state codes and helper functions for the XXH64 stream hash core.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    localparam int STATE_W = 20;

    typedef enum logic [STATE_W-1:0] {
        S_IDLE   = 20'h00001,
        S_LN_A   = 20'h00002,
        S_LN_B   = 20'h00004,
        S_FIN    = 20'h00008,
        S_SUM    = 20'h00010,
        S_MG_A   = 20'h00020,
        S_MG_B   = 20'h00040,
        S_MG_C   = 20'h00080,
        S_ADDLEN = 20'h00100,
        S_TSEL   = 20'h00200,
        S_T8_A   = 20'h00400,
        S_T8_B   = 20'h00800,
        S_T8_C   = 20'h01000,
        S_T4_A   = 20'h02000,
        S_T4_B   = 20'h04000,
        S_T1_A   = 20'h08000,
        S_T1_B   = 20'h10000,
        S_AV_A   = 20'h20000,
        S_AV_B   = 20'h40000,
        S_OUT    = 20'h80000
    } t_state;

    // multiply sub-cycles: three partial products, then write back
    typedef enum logic [1:0] {
        MC_LL = 2'd0,
        MC_LH = 2'd1,
        MC_HL = 2'd2,
        MC_WB = 2'd3
    } t_mcyc;

    function automatic logic [63:0] rotl31(input logic [63:0] x);
        rotl31 = {x[32:0], x[63:33]};
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic logic [63:0] lane_start(input logic [63:0] seed,
                                               input logic [1:0] idx);
        unique case (idx)
            2'd0: lane_start = seed + P1 + P2;
            2'd1: lane_start = seed + P2;
            2'd2: lane_start = seed;
            default: lane_start = seed - P1;
        endcase
    endfunction

endpackage

>>> rtl/xxh64_stream_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_stream_hash_core
// Streaming XXH64 digest over little-endian 64-bit words.
// ----------------------------------------------------------------------------
// A word that does not complete a 32-byte stripe is simply buffered. A word
// that completes a stripe runs the four lane rounds as eight 64-bit multiplies
// on one shared 32x32 multiplier, each as three partial products and a
// write-back. On the last word the finish sums and merges the lanes when a
// stripe was seen, then adds the length and folds in each 8-byte tail word, a
// 4-byte tail and each tail byte (each after its selection step), then runs the
// avalanche, and the result is held in an output register until taken. Input
// is stalled while busy.
module xxh64_stream_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    xxh_pkg::t_state r_state, n_state;
    xxh_pkg::t_mcyc  r_mc;

    logic [63:0] r_seed;
    logic [63:0] r_lane [4];
    logic [63:0] r_buf  [4];
    logic [5:0]  r_bb;
    logic [63:0] r_len;
    logic        r_seen;
    logic        r_last;
    logic [1:0]  r_i;
    logic [63:0] r_t;
    logic [63:0] r_h;
    logic [63:0] r_p;
    logic [4:0]  r_pos;
    logic [4:0]  r_left;

    logic        in_acc;
    logic [3:0]  eff_cnt;
    logic [63:0] masked_word;
    logic [5:0]  sum_bb;
    logic        is_mul;
    logic [63:0] mul_a, mul_c;
    logic [31:0] mx, my;
    logic [63:0] prod;
    logic [63:0] tail_word;
    logic [7:0]  tail_byte;
    logic [63:0] sum_term;

    assign o_in_stall  = (r_state != xxh_pkg::S_IDLE);
    assign o_out_valid = (r_state == xxh_pkg::S_OUT);
    assign in_acc      = i_in_valid && !o_in_stall;

    // short count only counts on the last word; above eight counts as eight
    assign eff_cnt = (!i_last_word || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;

    always_comb begin
        masked_word = i_data_word;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) >= eff_cnt) masked_word[k*8 +: 8] = 8'h00;
        end
    end

    assign sum_bb    = r_bb + {2'b00, eff_cnt};
    assign tail_word = r_buf[r_pos[4:3]];
    assign tail_byte = 8'(tail_word >> {r_pos[2:0], 3'b000});

    always_comb begin
        unique case (r_i)
            2'd0: sum_term = xxh_pkg::rotl(r_lane[0], 6'd1);
            2'd1: sum_term = xxh_pkg::rotl(r_lane[1], 6'd7);
            2'd2: sum_term = xxh_pkg::rotl(r_lane[2], 6'd12);
            default: sum_term = xxh_pkg::rotl(r_lane[3], 6'd18);
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        is_mul = 1'b1;
        mul_a  = 64'd0;
        mul_c  = 64'd0;
        unique case (r_state)
            xxh_pkg::S_LN_A: begin mul_a = r_buf[r_i];  mul_c = xxh_pkg::P2; end
            xxh_pkg::S_LN_B: begin mul_a = r_t;         mul_c = xxh_pkg::P1; end
            xxh_pkg::S_MG_A: begin mul_a = r_lane[r_i]; mul_c = xxh_pkg::P2; end
            xxh_pkg::S_MG_B: begin mul_a = r_t;         mul_c = xxh_pkg::P1; end
            xxh_pkg::S_MG_C: begin mul_a = r_h;         mul_c = xxh_pkg::P1; end
            xxh_pkg::S_T8_A: begin mul_a = tail_word;   mul_c = xxh_pkg::P2; end
            xxh_pkg::S_T8_B: begin mul_a = r_t;         mul_c = xxh_pkg::P1; end
            xxh_pkg::S_T8_C: begin
                mul_a = xxh_pkg::rotl(r_h, 6'd27); mul_c = xxh_pkg::P1;
            end
            xxh_pkg::S_T4_A: begin
                mul_a = {32'd0, tail_word[31:0]}; mul_c = xxh_pkg::P1;
            end
            xxh_pkg::S_T4_B: begin
                mul_a = xxh_pkg::rotl(r_h, 6'd23); mul_c = xxh_pkg::P2;
            end
            xxh_pkg::S_T1_A: begin mul_a = {56'd0, tail_byte}; mul_c = xxh_pkg::P5; end
            xxh_pkg::S_T1_B: begin
                mul_a = xxh_pkg::rotl(r_h, 6'd11); mul_c = xxh_pkg::P1;
            end
            xxh_pkg::S_AV_A: begin mul_a = r_h ^ (r_h >> 33); mul_c = xxh_pkg::P2; end
            xxh_pkg::S_AV_B: begin mul_a = r_h;               mul_c = xxh_pkg::P3; end
            default: is_mul = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_mc)
            xxh_pkg::MC_LL: begin mx = mul_a[31:0];  my = mul_c[31:0];  end
            xxh_pkg::MC_LH: begin mx = mul_a[31:0];  my = mul_c[63:32]; end
            default:        begin mx = mul_a[63:32]; my = mul_c[31:0];  end
        endcase
        prod = {32'd0, mx} * {32'd0, my};
    end

    logic wb;
    assign wb = is_mul && (r_mc == xxh_pkg::MC_WB);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xxh_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (sum_bb >= 6'd32)  n_state = xxh_pkg::S_LN_A;
                    else if (i_last_word) n_state = xxh_pkg::S_FIN;
                end
            end
            xxh_pkg::S_LN_A: if (wb) n_state = xxh_pkg::S_LN_B;
            xxh_pkg::S_LN_B: begin
                if (wb) begin
                    if (r_i != 2'd3)  n_state = xxh_pkg::S_LN_A;
                    else if (r_last)  n_state = xxh_pkg::S_FIN;
                    else              n_state = xxh_pkg::S_IDLE;
                end
            end
            xxh_pkg::S_FIN: n_state = r_seen ? xxh_pkg::S_SUM : xxh_pkg::S_ADDLEN;
            xxh_pkg::S_SUM: if (r_i == 2'd3) n_state = xxh_pkg::S_MG_A;
            xxh_pkg::S_MG_A: if (wb) n_state = xxh_pkg::S_MG_B;
            xxh_pkg::S_MG_B: if (wb) n_state = xxh_pkg::S_MG_C;
            xxh_pkg::S_MG_C: begin
                if (wb) n_state = (r_i == 2'd3) ? xxh_pkg::S_ADDLEN : xxh_pkg::S_MG_A;
            end
            xxh_pkg::S_ADDLEN: n_state = xxh_pkg::S_TSEL;
            xxh_pkg::S_TSEL: begin
                priority if (r_left >= 5'd8) n_state = xxh_pkg::S_T8_A;
                else if (r_left >= 5'd4)     n_state = xxh_pkg::S_T4_A;
                else if (r_left != 5'd0)     n_state = xxh_pkg::S_T1_A;
                else                         n_state = xxh_pkg::S_AV_A;
            end
            xxh_pkg::S_T8_A: if (wb) n_state = xxh_pkg::S_T8_B;
            xxh_pkg::S_T8_B: if (wb) n_state = xxh_pkg::S_T8_C;
            xxh_pkg::S_T8_C: if (wb) n_state = xxh_pkg::S_TSEL;
            xxh_pkg::S_T4_A: if (wb) n_state = xxh_pkg::S_T4_B;
            xxh_pkg::S_T4_B: if (wb) n_state = xxh_pkg::S_TSEL;
            xxh_pkg::S_T1_A: if (wb) n_state = xxh_pkg::S_T1_B;
            xxh_pkg::S_T1_B: if (wb) n_state = xxh_pkg::S_TSEL;
            xxh_pkg::S_AV_A: if (wb) n_state = xxh_pkg::S_AV_B;
            xxh_pkg::S_AV_B: if (wb) n_state = xxh_pkg::S_OUT;
            xxh_pkg::S_OUT:  if (!i_out_stall) n_state = xxh_pkg::S_IDLE;
            default: n_state = xxh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xxh_pkg::S_IDLE;
            r_mc    <= xxh_pkg::MC_LL;
            r_seed  <= 64'd0;
            for (int k = 0; k < 4; k++) r_lane[k] <= xxh_pkg::lane_start(64'd0, 2'(k));
            r_bb    <= 6'd0;
            r_len   <= 64'd0;
            r_seen  <= 1'b0;
            r_last  <= 1'b0;
            r_i     <= 2'd0;
        end else if (i_cfg_wr_en) begin
            // new seed: drop any message and restart
            r_state <= xxh_pkg::S_IDLE;
            r_mc    <= xxh_pkg::MC_LL;
            r_seed  <= i_cfg_wr_data;
            for (int k = 0; k < 4; k++) begin
                r_lane[k] <= xxh_pkg::lane_start(i_cfg_wr_data, 2'(k));
            end
            r_bb    <= 6'd0;
            r_len   <= 64'd0;
            r_seen  <= 1'b0;
            r_i     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (is_mul) begin
                unique case (r_mc)
                    xxh_pkg::MC_LL: r_mc <= xxh_pkg::MC_LH;
                    xxh_pkg::MC_LH: r_mc <= xxh_pkg::MC_HL;
                    xxh_pkg::MC_HL: r_mc <= xxh_pkg::MC_WB;
                    default:        r_mc <= xxh_pkg::MC_LL;
                endcase
            end

            unique case (r_state)
                xxh_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_buf[r_bb[4:3]] <= masked_word;
                        r_len  <= r_len + {60'd0, eff_cnt};
                        r_last <= i_last_word;
                        r_i    <= 2'd0;
                        if (sum_bb >= 6'd32) begin
                            r_bb   <= 6'd0;
                            r_seen <= 1'b1;
                        end else begin
                            r_bb <= sum_bb;
                        end
                    end
                end
                xxh_pkg::S_LN_A: if (wb) r_t <= xxh_pkg::rotl31(r_lane[r_i] + r_p);
                xxh_pkg::S_LN_B: begin
                    if (wb) begin
                        r_lane[r_i] <= r_p;
                        r_i <= r_i + 2'd1;
                    end
                end
                xxh_pkg::S_FIN: begin
                    r_i <= 2'd0;
                    r_h <= r_seen ? 64'd0 : r_seed + xxh_pkg::P5;
                end
                xxh_pkg::S_SUM: begin
                    r_h <= r_h + sum_term;
                    r_i <= r_i + 2'd1;
                end
                xxh_pkg::S_MG_A: if (wb) r_t <= xxh_pkg::rotl31(r_p);
                xxh_pkg::S_MG_B: if (wb) r_h <= r_h ^ r_p;
                xxh_pkg::S_MG_C: begin
                    if (wb) begin
                        r_h <= r_p + xxh_pkg::P4;
                        r_i <= r_i + 2'd1;
                    end
                end
                xxh_pkg::S_ADDLEN: begin
                    r_h    <= r_h + r_len;
                    r_pos  <= 5'd0;
                    r_left <= r_bb[4:0];
                end
                xxh_pkg::S_TSEL: ;
                xxh_pkg::S_T8_A: if (wb) r_t <= xxh_pkg::rotl31(r_p);
                xxh_pkg::S_T8_B: if (wb) r_h <= r_h ^ r_p;
                xxh_pkg::S_T8_C: begin
                    if (wb) begin
                        r_h    <= r_p + xxh_pkg::P4;
                        r_pos  <= r_pos + 5'd8;
                        r_left <= r_left - 5'd8;
                    end
                end
                xxh_pkg::S_T4_A: if (wb) r_h <= r_h ^ r_p;
                xxh_pkg::S_T4_B: begin
                    if (wb) begin
                        r_h    <= r_p + xxh_pkg::P3;
                        r_pos  <= r_pos + 5'd4;
                        r_left <= r_left - 5'd4;
                    end
                end
                xxh_pkg::S_T1_A: if (wb) r_h <= r_h ^ r_p;
                xxh_pkg::S_T1_B: begin
                    if (wb) begin
                        r_h    <= r_p;
                        r_pos  <= r_pos + 5'd1;
                        r_left <= r_left - 5'd1;
                    end
                end
                xxh_pkg::S_AV_A: if (wb) r_h <= r_p ^ (r_p >> 29);
                xxh_pkg::S_AV_B: if (wb) r_h <= r_p ^ (r_p >> 32);
                xxh_pkg::S_OUT: begin
                    // word taken: restart from the seed for the next message
                    if (!i_out_stall) begin
                        for (int k = 0; k < 4; k++) begin
                            r_lane[k] <= xxh_pkg::lane_start(r_seed, 2'(k));
                        end
                        r_bb   <= 6'd0;
                        r_len  <= 64'd0;
                        r_seen <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // partial products accumulate into r_p
    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            unique case (r_mc)
                xxh_pkg::MC_LL: r_p <= prod;
                xxh_pkg::MC_LH: r_p <= r_p + {prod[31:0], 32'd0};
                xxh_pkg::MC_HL: r_p <= r_p + {prod[31:0], 32'd0};
                default: ;
            endcase
        end
    end

    assign o_hash_value = r_h;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    a_idle_mc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xxh_pkg::S_IDLE) |-> (r_mc == xxh_pkg::MC_LL))
        else $error("multiply sequencer not at rest in idle");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && !i_cfg_wr_en) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule
